// ----- hw/rtl/sctt_pkg.sv -----
// Package for the sine/cosine/tangent table unit: widths, codes and the
// quarter-wave sine ROM in Q1.14. No dependencies.
package sctt_pkg;

    localparam int TABLE_ENTRIES = 181;
    localparam int TABLE_FRAC    = 14;
    localparam int FULL_TURN     = 3600;
    localparam int QUARTER_TURN  = 900;
    localparam int HALF_TURN     = 1800;
    localparam int THREE_QUARTER = 2700;

    localparam int REQ_W   = 2;
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 24;
    localparam int POLE_W  = 3;
    localparam int MAG_W   = 15;
    localparam int IDX_W   = 8;
    localparam int DEG_W   = 12;
    localparam int FOLD_W  = 10;

    // n / 3600 = (n >> 4) / 225, approximated by a reciprocal multiply.
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP = 29'd305419896;
    localparam int PROD_W = (ANGLE_W - 4) + RECIP_W;
    localparam int QUO_W  = 21;

    // x / 5 = (x * 205) >> 10 for x below 1024.
    localparam logic [7:0] DIV5_MUL = 8'd205;
    localparam int DIV5_SHIFT = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_SIN = 2'd0,
        REQ_COS = 2'd1,
        REQ_TAN = 2'd2
    } req_t;

    typedef enum logic [POLE_W-1:0] {
        POLE_NONE     = 3'd0,
        POLE_EVEN_LOW = 3'd1,
        POLE_EVEN_HI  = 3'd2,
        POLE_ODD_LOW  = 3'd3,
        POLE_ODD_HI   = 3'd4
    } pole_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic              s_neg;
        logic              c_neg;
        logic [MAG_W-1:0]  s_mag;
        logic [MAG_W-1:0]  c_mag;
        logic [POLE_W-1:0] pole;
    } side_t;

    localparam logic [MAG_W-1:0] QUARTER_ROM [TABLE_ENTRIES] = '{
        15'd0, 15'd143, 15'd286, 15'd429, 15'd572, 15'd715, 15'd857, 15'd1000,
        15'd1143, 15'd1285, 15'd1428, 15'd1570, 15'd1713, 15'd1855, 15'd1997,
        15'd2139, 15'd2280, 15'd2422, 15'd2563, 15'd2704, 15'd2845, 15'd2986,
        15'd3126, 15'd3266, 15'd3406, 15'd3546, 15'd3686, 15'd3825, 15'd3964,
        15'd4102, 15'd4240, 15'd4378, 15'd4516, 15'd4653, 15'd4790, 15'd4927,
        15'd5063, 15'd5199, 15'd5334, 15'd5469, 15'd5604, 15'd5738, 15'd5872,
        15'd6005, 15'd6138, 15'd6270, 15'd6402, 15'd6533, 15'd6664, 15'd6794,
        15'd6924, 15'd7053, 15'd7182, 15'd7311, 15'd7438, 15'd7565, 15'd7692,
        15'd7818, 15'd7943, 15'd8068, 15'd8192, 15'd8316, 15'd8438, 15'd8561,
        15'd8682, 15'd8803, 15'd8923, 15'd9043, 15'd9162, 15'd9280, 15'd9397,
        15'd9514, 15'd9630, 15'd9746, 15'd9860, 15'd9974, 15'd10087, 15'd10199,
        15'd10311, 15'd10422, 15'd10531, 15'd10641, 15'd10749, 15'd10856,
        15'd10963, 15'd11069, 15'd11174, 15'd11278, 15'd11381, 15'd11484,
        15'd11585, 15'd11686, 15'd11786, 15'd11885, 15'd11982, 15'd12080,
        15'd12176, 15'd12271, 15'd12365, 15'd12458, 15'd12551, 15'd12642,
        15'd12733, 15'd12822, 15'd12911, 15'd12998, 15'd13085, 15'd13170,
        15'd13255, 15'd13338, 15'd13421, 15'd13502, 15'd13583, 15'd13662,
        15'd13741, 15'd13818, 15'd13894, 15'd13970, 15'd14044, 15'd14117,
        15'd14189, 15'd14260, 15'd14330, 15'd14399, 15'd14466, 15'd14533,
        15'd14598, 15'd14663, 15'd14726, 15'd14788, 15'd14849, 15'd14909,
        15'd14968, 15'd15025, 15'd15082, 15'd15137, 15'd15191, 15'd15244,
        15'd15296, 15'd15346, 15'd15396, 15'd15444, 15'd15491, 15'd15537,
        15'd15582, 15'd15626, 15'd15668, 15'd15709, 15'd15749, 15'd15788,
        15'd15826, 15'd15862, 15'd15897, 15'd15931, 15'd15964, 15'd15996,
        15'd16026, 15'd16055, 15'd16083, 15'd16110, 15'd16135, 15'd16159,
        15'd16182, 15'd16204, 15'd16225, 15'd16244, 15'd16262, 15'd16279,
        15'd16294, 15'd16309, 15'd16322, 15'd16333, 15'd16344, 15'd16353,
        15'd16362, 15'd16368, 15'd16374, 15'd16378, 15'd16382, 15'd16383,
        15'd16384
    };

    function automatic logic [MAG_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
        logic [MAG_W-1:0] r;
        r = '0;
        if (idx < IDX_W'(TABLE_ENTRIES))
        begin
            r = QUARTER_ROM[idx];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/sctt_if.sv -----
// Valid/ready channel interfaces for the table unit's request and result.
// Depends on sctt_pkg.
interface sctt_req_if;
    import sctt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [ANGLE_W-1:0] angle;
    modport source (output valid, req_type, angle, input ready);
    modport sink (input valid, req_type, angle, output ready);
endinterface

interface sctt_res_if;
    import sctt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [POLE_W-1:0]         pole_code;
    modport source (output valid, value, pole_code, input ready);
    modport sink (input valid, value, pole_code, output ready);
endinterface

// ----- hw/rtl/sctt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sctt_pkg; stage enables come from the top level.
module sctt_div
    import sctt_pkg::*;
#(
    parameter int NUM_W = 31
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] en,
    input  logic [NUM_W-1:0] num,
    input  logic [MAG_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [MAG_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [MAG_W-1:0] den_reg [NUM_W];

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_stage
        logic [MAG_W-1:0] rem_prev;
        logic [NUM_W-1:0] num_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [MAG_W-1:0] den_prev;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rem_prev = '0;
            assign num_prev = num;
            assign quo_prev = '0;
            assign den_prev = den;
        end
        else
        begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign num_prev = num_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign den_prev = den_reg[j-1];
        end

        assign trial = {rem_prev, num_prev[NUM_W-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign ge    = (trial >= {1'b0, den_prev});

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                num_reg[j] <= {num_prev[NUM_W-2:0], 1'b0};
                quo_reg[j] <= {quo_prev[NUM_W-2:0], ge};
                den_reg[j] <= den_prev;
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

// ----- hw/rtl/sin_cos_tan_table_unit_top.sv -----
// Sine/cosine/tangent quarter-wave table unit, top level.
// Depends on sctt_pkg, sctt_if and sctt_div.
//
//   channel  role    payload
//   req_ch   sink    req_type (0 sine, 1 cosine, 2 tangent), angle (0.1 deg)
//   res_ch   source  value (signed, FRACTION_BITS fraction bits), pole_code
//
// One transaction enters per cycle while the pipeline is not stalled; each
// result passes through the five front stages, the one-bit-per-stage tangent
// divider and the output register.
// Reset clears the stage valid bits only; no clearing pass is needed.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and a request is taken whenever the front stage can move.
module sin_cos_tan_table_unit_top
    import sctt_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    sctt_req_if.sink     req_ch,
    sctt_res_if.source   res_ch
);

    localparam int NUM_W  = MAG_W + FRACTION_BITS;
    localparam int FRONT  = 5;
    localparam int NS     = FRONT + NUM_W + 1;
    localparam logic [NUM_W-1:0] SAT_LIM = NUM_W'(1) << (VALUE_W - 1);

    // stage valid bits and the ready chain
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS:0]   rdy;

    always_comb
    begin
        rdy[NS] = res_ch.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NS; i++)
        begin
            if (!rdy[i])
            begin
                v_next[i] = v_reg[i];
            end
            else if (i == 0)
            begin
                v_next[i] = req_ch.valid;
            end
            else
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_ch.ready = rdy[0];

    // stage A: magnitude and sign of the angle
    logic [REQ_W-1:0]   a_req_reg;
    logic               a_neg_reg;
    logic [ANGLE_W-1:0] a_mag_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            a_req_reg <= req_ch.req_type;
            a_neg_reg <= req_ch.angle[ANGLE_W-1];
            a_mag_reg <= req_ch.angle[ANGLE_W-1] ? ANGLE_W'(-req_ch.angle)
                                                 : ANGLE_W'(req_ch.angle);
        end
    end

    // stage B: reciprocal multiply for the turn count
    logic [REQ_W-1:0]   b_req_reg;
    logic               b_neg_reg;
    logic [ANGLE_W-1:0] b_mag_reg;
    logic [PROD_W-1:0]  b_prod_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            b_req_reg  <= a_req_reg;
            b_neg_reg  <= a_neg_reg;
            b_mag_reg  <= a_mag_reg;
            b_prod_reg <= PROD_W'(a_mag_reg[ANGLE_W-1:4]) * PROD_W'(RECIP);
        end
    end

    // stage C: remainder with one correction step; keep turn parity only
    logic [QUO_W-1:0]     c_q0;
    logic [ANGLE_W:0]     c_r0_full;
    logic [DEG_W:0]       c_r0;
    logic                 c_corr;
    logic [REQ_W-1:0]     c_req_reg;
    logic                 c_neg_reg;
    logic [DEG_W-1:0]     c_rem_reg;
    logic                 c_qpar_reg;

    assign c_q0      = b_prod_reg[RECIP_SHIFT +: QUO_W];
    assign c_r0_full = {1'b0, b_mag_reg}
                       - ((ANGLE_W + 1)'(c_q0) * (ANGLE_W + 1)'(FULL_TURN));
    assign c_r0      = c_r0_full[DEG_W:0];
    assign c_corr    = (c_r0 >= (DEG_W + 1)'(FULL_TURN));

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            c_req_reg  <= b_req_reg;
            c_neg_reg  <= b_neg_reg;
            c_rem_reg  <= c_corr ? DEG_W'(c_r0 - (DEG_W + 1)'(FULL_TURN))
                                 : c_r0[DEG_W-1:0];
            c_qpar_reg <= c_q0[0] ^ c_corr;
        end
    end

    // stage D: reduced angle, quadrant fold, divide by five
    logic [DEG_W-1:0]  d_ang;
    logic              d_odd;
    logic [FOLD_W-1:0] d_sx;
    logic [FOLD_W-1:0] d_cx;
    logic              d_sneg;
    logic              d_cneg;
    logic [FOLD_W+7:0] d_sprod;
    logic [FOLD_W+7:0] d_cprod;

    always_comb
    begin
        if (c_neg_reg && c_rem_reg != '0)
        begin
            d_ang = DEG_W'(FULL_TURN) - c_rem_reg;
        end
        else
        begin
            d_ang = c_rem_reg;
        end
        d_odd = c_qpar_reg ^ (c_neg_reg && c_rem_reg != '0);

        if (d_ang <= DEG_W'(QUARTER_TURN))
        begin
            d_sx = FOLD_W'(d_ang);
            d_cx = FOLD_W'(DEG_W'(QUARTER_TURN) - d_ang);
            d_sneg = 1'b0;
            d_cneg = 1'b0;
        end
        else if (d_ang <= DEG_W'(HALF_TURN))
        begin
            d_sx = FOLD_W'(DEG_W'(HALF_TURN) - d_ang);
            d_cx = FOLD_W'(d_ang - DEG_W'(QUARTER_TURN));
            d_sneg = 1'b0;
            d_cneg = 1'b1;
        end
        else if (d_ang <= DEG_W'(THREE_QUARTER))
        begin
            d_sx = FOLD_W'(d_ang - DEG_W'(HALF_TURN));
            d_cx = FOLD_W'(DEG_W'(THREE_QUARTER) - d_ang);
            d_sneg = 1'b1;
            d_cneg = 1'b1;
        end
        else
        begin
            d_sx = FOLD_W'(DEG_W'(FULL_TURN) - d_ang);
            d_cx = FOLD_W'(d_ang - DEG_W'(THREE_QUARTER));
            d_sneg = 1'b1;
            d_cneg = 1'b0;
        end
        d_sprod = (FOLD_W + 8)'(d_sx) * (FOLD_W + 8)'(DIV5_MUL);
        d_cprod = (FOLD_W + 8)'(d_cx) * (FOLD_W + 8)'(DIV5_MUL);
    end

    logic [REQ_W-1:0] d_req_reg;
    logic [IDX_W-1:0] d_sidx_reg;
    logic [IDX_W-1:0] d_cidx_reg;
    logic             d_sneg_reg;
    logic             d_cneg_reg;
    logic             d_upper_reg;
    logic             d_odd_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            d_req_reg   <= c_req_reg;
            d_sidx_reg  <= d_sprod[DIV5_SHIFT +: IDX_W];
            d_cidx_reg  <= d_cprod[DIV5_SHIFT +: IDX_W];
            d_sneg_reg  <= d_sneg;
            d_cneg_reg  <= d_cneg;
            d_upper_reg <= (d_ang >= DEG_W'(HALF_TURN));
            d_odd_reg   <= d_odd;
        end
    end

    // stage E: table lookups and the pole code
    side_t            e_side;
    side_t            e_side_reg;

    always_comb
    begin
        e_side.req   = d_req_reg;
        e_side.s_neg = d_sneg_reg;
        e_side.c_neg = d_cneg_reg;
        e_side.s_mag = rom_read(d_sidx_reg);
        e_side.c_mag = rom_read(d_cidx_reg);
        e_side.pole  = POLE_NONE;
        if (d_req_reg == REQ_TAN && e_side.c_mag == '0)
        begin
            case ({d_odd_reg, d_upper_reg})
                2'b00:   e_side.pole = POLE_EVEN_LOW;
                2'b01:   e_side.pole = POLE_EVEN_HI;
                2'b10:   e_side.pole = POLE_ODD_LOW;
                default: e_side.pole = POLE_ODD_HI;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            e_side_reg <= e_side;
        end
    end

    // divider stages: tangent magnitude, side data travels alongside
    logic [NUM_W-1:0] div_quo;
    side_t            side_reg [NUM_W];

    sctt_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk (clk),
        .en  (rdy[FRONT +: NUM_W]),
        .num ({e_side_reg.s_mag, FRACTION_BITS'(0)}),
        .den (e_side_reg.c_mag),
        .quo (div_quo)
    );

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_W; j++)
        begin
            if (rdy[FRONT + j])
            begin
                side_reg[j] <= (j == 0) ? e_side_reg : side_reg[j-1];
            end
        end
    end

    // output stage: select, sign and saturate
    side_t                     o_side;
    logic [NUM_W-1:0]          o_mag;
    logic                      o_neg;
    logic signed [VALUE_W-1:0] o_value;
    logic signed [VALUE_W-1:0] value_reg;
    logic [POLE_W-1:0]         pole_reg;

    always_comb
    begin
        o_side = side_reg[NUM_W-1];
        o_mag  = '0;
        o_neg  = 1'b0;
        case (o_side.req)
            REQ_SIN:
            begin
                o_mag = NUM_W'(o_side.s_mag) << (FRACTION_BITS - TABLE_FRAC);
                o_neg = o_side.s_neg;
            end
            REQ_COS:
            begin
                o_mag = NUM_W'(o_side.c_mag) << (FRACTION_BITS - TABLE_FRAC);
                o_neg = o_side.c_neg;
            end
            REQ_TAN:
            begin
                if (o_side.pole == POLE_NONE)
                begin
                    o_mag = div_quo;
                    o_neg = o_side.s_neg ^ o_side.c_neg;
                end
            end
            default:
            begin
                o_mag = '0;
            end
        endcase

        if (o_neg)
        begin
            o_value = (o_mag > SAT_LIM) ? VALUE_W'(-SAT_LIM) : VALUE_W'(-o_mag);
        end
        else
        begin
            o_value = (o_mag > SAT_LIM - 1'b1) ? VALUE_W'(SAT_LIM - 1'b1)
                                                : VALUE_W'(o_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            value_reg <= o_value;
            pole_reg  <= o_side.pole;
        end
    end

    assign res_ch.valid     = v_reg[NS-1];
    assign res_ch.value     = value_reg;
    assign res_ch.pole_code = pole_reg;

`ifndef SYNTHESIS
    a_pole_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.pole_code != POLE_NONE |-> res_ch.value == '0)
        else $error("pole result carries a nonzero value");

    a_pole_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> res_ch.pole_code <= POLE_ODD_HI)
        else $error("pole code out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_ch.valid |-> req_ch.ready)
        else $error("request stalled with an empty output register");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        req_ch.valid && req_ch.ready && !(res_ch.valid && res_ch.ready)
        |=> $countones(v_reg) == $past($countones(v_reg)) + 1)
        else $error("pipeline lost or duplicated a transaction");
`endif

endmodule
